>>> rtl/ppid_pkg.sv
// Package: widths, reset values, codes and shared types of the positional PID controller.
package ppid_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int SUM_W       = 32;
    localparam int GAIN_FRAC_W = 16;
    localparam int RATIO_W     = 24;
    localparam int DRIVE_W     = 32;
    localparam int CFG_INDEX_W = 2;

    localparam int CFG_DATA_W = (SAMPLE_W > RATIO_W) ? SAMPLE_W : RATIO_W;
    localparam int S_TDATA_W  = ((SAMPLE_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((DRIVE_W + 7) / 8) * 8;

    localparam int ERR_W  = SAMPLE_W + 1;
    localparam int DIFF_W = SAMPLE_W + 2;
    localparam int SUMX_W = ((SUM_W > ERR_W) ? SUM_W : ERR_W) + 1;

    localparam int MUL_A_W = (SUM_W > DIFF_W) ? SUM_W : DIFF_W;
    localparam int PROD_W  = MUL_A_W + RATIO_W;

    localparam int TERM_CAP_W = 61;
    localparam int TERM_MAG_W = (PROD_W > TERM_CAP_W) ? TERM_CAP_W : PROD_W;
    localparam int CAPCMP_W   = (PROD_W > TERM_CAP_W + 1) ? PROD_W : TERM_CAP_W + 1;
    localparam logic [TERM_CAP_W:0] TERM_CAP = {1'b0, {TERM_CAP_W{1'b1}}};

    localparam int PTERM_W = ERR_W + GAIN_FRAC_W;
    localparam int ACC_W   = ((TERM_MAG_W > PTERM_W) ? TERM_MAG_W : PTERM_W) + 3;
    localparam int HALF_W  = (ACC_W + 1) / 2;

    localparam int FULL_W = ACC_W + RATIO_W + 1;
    localparam int RND_SH = 2 * GAIN_FRAC_W;
    localparam int RES_W  = FULL_W - RND_SH;
    localparam int DCMP_W = (RES_W > DRIVE_W + 1) ? RES_W : DRIVE_W + 1;

    localparam logic [SAMPLE_W-1:0] SET_POINT_RST = SAMPLE_W'(1);
    localparam logic [RATIO_W-1:0]  RATIO_ONE     = RATIO_W'(64'd1 << GAIN_FRAC_W);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SET_POINT,
        REG_GAIN,
        REG_INTEGRAL,
        REG_DERIVATIVE
    } cfg_reg_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] set_point;
        logic [RATIO_W-1:0]  gain;
        logic [RATIO_W-1:0]  integral_ratio;
        logic [RATIO_W-1:0]  derivative_ratio;
    } cfg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_I,
        S_ADD_I,
        S_MUL_D,
        S_ADD_D,
        S_MAG,
        S_MUL_GL,
        S_MUL_GH,
        S_RND
    } state_t;

endpackage

>>> rtl/ppid_cfg.sv
// Configuration register file: set point, gain and the two term ratios.
module ppid_cfg
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [ppid_pkg::CFG_INDEX_W-1:0] cfg_wr_index,
    input  logic [ppid_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    output ppid_pkg::cfg_t                   cfg
);

    ppid_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.set_point        <= ppid_pkg::SET_POINT_RST;
            cfg_reg.gain             <= ppid_pkg::RATIO_ONE;
            cfg_reg.integral_ratio   <= ppid_pkg::RATIO_ONE;
            cfg_reg.derivative_ratio <= ppid_pkg::RATIO_ONE;
        end
        else if (cfg_wr_en)
        begin
            unique case (ppid_pkg::cfg_reg_t'(cfg_wr_index))
                ppid_pkg::REG_SET_POINT:
                    cfg_reg.set_point <= cfg_wr_data[ppid_pkg::SAMPLE_W-1:0];
                ppid_pkg::REG_GAIN:
                    cfg_reg.gain <= cfg_wr_data[ppid_pkg::RATIO_W-1:0];
                ppid_pkg::REG_INTEGRAL:
                    cfg_reg.integral_ratio <= cfg_wr_data[ppid_pkg::RATIO_W-1:0];
                ppid_pkg::REG_DERIVATIVE:
                    cfg_reg.derivative_ratio <= cfg_wr_data[ppid_pkg::RATIO_W-1:0];
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/ppid_mul.sv
// Shared unsigned multiplier with a registered product.
module ppid_mul
(
    input  logic                         clk,
    input  logic                         en,
    input  logic [ppid_pkg::MUL_A_W-1:0] a,
    input  logic [ppid_pkg::RATIO_W-1:0] b,
    output logic [ppid_pkg::PROD_W-1:0]  prod
);

    logic [ppid_pkg::PROD_W-1:0] prod_reg;

    // Hold the product until the sequencer asks for the next one.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= ppid_pkg::PROD_W'(a) * ppid_pkg::PROD_W'(b);
        end
    end

    assign prod = prod_reg;

endmodule

>>> rtl/positional_pid_controller.sv
// Top level: sequencer and datapath of the fixed-point positional PID controller.
//
// Each request carries one measured sample; the block answers it with one drive value
// and a clipped flag. One multiplier is shared by the integral product, the derivative
// product and the two halves of the gain product, so a sample runs through a nine-step
// sequencer: the cycle the sample is taken, two multiply/accumulate pairs, a magnitude
// step, two gain multiplies and a round-and-saturate step. s_tready is high only while
// the sequencer is idle, so the block takes no new sample until the last is through;
// a finished result sits in the output register, so the next sample is taken while it
// waits. The error sum saturates at the signed SUM_W range, each ratio product is capped
// at 2^61-1, and drive is rounded half away from zero and saturated to 32 bits signed;
// any of these sets clipped. The user must write the configuration registers (set point,
// gain, integral, derivative ratio) via cfg_wr_* only with no sample in flight; unchecked.
module positional_pid_controller
(
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             cfg_wr_en,
    input  logic [ppid_pkg::CFG_INDEX_W-1:0] cfg_wr_index,
    input  logic [ppid_pkg::CFG_DATA_W-1:0]  cfg_wr_data,

    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [ppid_pkg::S_TDATA_W-1:0]   s_tdata,  // [SAMPLE_W-1:0] sample

    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [ppid_pkg::M_TDATA_W-1:0]   m_tdata,  // [31:0] drive
    output logic [0:0]                       m_tuser   // [0] clipped
);

    localparam int SAMPLE_W = ppid_pkg::SAMPLE_W;
    localparam int SUM_W    = ppid_pkg::SUM_W;
    localparam int ERR_W    = ppid_pkg::ERR_W;
    localparam int DIFF_W   = ppid_pkg::DIFF_W;
    localparam int SUMX_W   = ppid_pkg::SUMX_W;
    localparam int MUL_A_W  = ppid_pkg::MUL_A_W;
    localparam int PROD_W   = ppid_pkg::PROD_W;
    localparam int ACC_W    = ppid_pkg::ACC_W;
    localparam int HALF_W   = ppid_pkg::HALF_W;
    localparam int FULL_W   = ppid_pkg::FULL_W;
    localparam int RND_SH   = ppid_pkg::RND_SH;
    localparam int RES_W    = ppid_pkg::RES_W;
    localparam int DCMP_W   = ppid_pkg::DCMP_W;
    localparam int DRIVE_W  = ppid_pkg::DRIVE_W;
    localparam int RATIO_W  = ppid_pkg::RATIO_W;
    localparam int CAPCMP_W = ppid_pkg::CAPCMP_W;
    localparam int TMAG_W   = ppid_pkg::TERM_MAG_W;

    ppid_pkg::cfg_t   cfg;
    ppid_pkg::state_t state_reg;
    ppid_pkg::state_t state_next;

    // Loop state and sequencer registers.
    logic signed [SUM_W-1:0]  error_sum_reg;
    logic signed [ERR_W-1:0]  prev_err_reg;
    logic                     m_tvalid_reg;
    logic                     clip_reg;
    logic                     clip_next;

    // Working registers for one sample.
    logic signed [DIFF_W-1:0] diff_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic [ACC_W-1:0]         mag_reg;
    logic                     neg_reg;
    logic [PROD_W-1:0]        lo_reg;
    logic [DRIVE_W-1:0]       drive_reg;
    logic                     clipped_reg;

    logic                     in_acc;
    logic                     out_load;
    logic                     mul_en;
    logic [MUL_A_W-1:0]       mul_a;
    logic [RATIO_W-1:0]       mul_b;
    logic [PROD_W-1:0]        prod;

    ppid_cfg u_cfg
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .cfg          (cfg)
    );

    ppid_mul u_mul
    (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    assign s_tready = (state_reg == ppid_pkg::S_IDLE);
    assign in_acc   = s_tvalid && s_tready;

    // Error, saturating error sum and error change, formed the cycle the sample is taken.
    logic signed [ERR_W-1:0]  err;
    logic signed [SUMX_W-1:0] sumx;
    logic [SUMX_W-SUM_W:0]    sum_top;
    logic                     sum_ovf;
    logic signed [SUM_W-1:0]  sum_sat;
    logic signed [DIFF_W-1:0] diff;
    logic signed [ACC_W-1:0]  acc_init;

    assign err      = ERR_W'({1'b0, cfg.set_point}) - ERR_W'({1'b0, s_tdata[SAMPLE_W-1:0]});
    assign sumx     = SUMX_W'(error_sum_reg) + SUMX_W'(err);
    assign sum_top  = sumx[SUMX_W-1:SUM_W-1];
    assign sum_ovf  = !((&sum_top) || !(|sum_top));
    assign sum_sat  = sum_ovf ? {sumx[SUMX_W-1], {(SUM_W-1){!sumx[SUMX_W-1]}}}
                              : sumx[SUM_W-1:0];
    assign diff     = DIFF_W'(err) - DIFF_W'(prev_err_reg);
    assign acc_init = ACC_W'(err) <<< ppid_pkg::GAIN_FRAC_W;

    // Multiplier operands: magnitudes of the signed values.
    logic signed [MUL_A_W-1:0] sum_ext;
    logic signed [MUL_A_W-1:0] diff_ext;
    logic [MUL_A_W-1:0]        sum_mag;
    logic [MUL_A_W-1:0]        diff_mag;
    logic [MUL_A_W-1:0]        mag_lo;
    logic [MUL_A_W-1:0]        mag_hi;

    assign sum_ext  = MUL_A_W'(error_sum_reg);
    assign diff_ext = MUL_A_W'(diff_reg);
    assign sum_mag  = error_sum_reg[SUM_W-1] ? MUL_A_W'(-sum_ext) : MUL_A_W'(sum_ext);
    assign diff_mag = diff_reg[DIFF_W-1] ? MUL_A_W'(-diff_ext) : MUL_A_W'(diff_ext);
    assign mag_lo   = MUL_A_W'(mag_reg[HALF_W-1:0]);
    assign mag_hi   = MUL_A_W'(mag_reg[ACC_W-1:HALF_W]);

    // Ratio term: cap the product magnitude, then restore the sign of the multiplicand.
    logic                    cap_hit;
    logic [TMAG_W-1:0]       term_mag;
    logic signed [ACC_W-1:0] term_pos;
    logic                    term_neg;
    logic signed [ACC_W-1:0] term;

    assign cap_hit  = CAPCMP_W'(prod) > CAPCMP_W'(ppid_pkg::TERM_CAP);
    assign term_mag = cap_hit ? TMAG_W'(ppid_pkg::TERM_CAP) : TMAG_W'(prod);
    assign term_pos = $signed(ACC_W'(term_mag));
    assign term_neg = (state_reg == ppid_pkg::S_ADD_I) ? error_sum_reg[SUM_W-1]
                                                       : diff_reg[DIFF_W-1];
    assign term     = term_neg ? -term_pos : term_pos;

    // Gain product: join the two partial products, round half up on the magnitude,
    // saturate to the bound on the side of the sign.
    logic [FULL_W-1:0]  full;
    logic [RES_W-1:0]   res;
    logic [DCMP_W-1:0]  drive_cap;
    logic               drive_ovf;
    logic [DCMP_W-1:0]  res_cap;
    logic [DRIVE_W-1:0] drive_mag;
    logic [DRIVE_W-1:0] drive_val;

    assign full      = FULL_W'(lo_reg) + (FULL_W'(prod) << HALF_W)
                     + (FULL_W'(1) << (RND_SH - 1));
    assign res       = full[FULL_W-1:RND_SH];
    assign drive_cap = neg_reg ? (DCMP_W'(1) << (DRIVE_W - 1))
                               : ((DCMP_W'(1) << (DRIVE_W - 1)) - DCMP_W'(1));
    assign drive_ovf = DCMP_W'(res) > drive_cap;
    assign res_cap   = drive_ovf ? drive_cap : DCMP_W'(res);
    assign drive_mag = res_cap[DRIVE_W-1:0];
    assign drive_val = neg_reg ? (~drive_mag + DRIVE_W'(1)) : drive_mag;

    // Sequencer: next state, multiplier control and accumulator update.
    always_comb
    begin
        state_next = state_reg;
        mul_en     = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        out_load   = 1'b0;
        acc_next   = acc_reg;
        clip_next  = clip_reg;
        unique case (state_reg)
            ppid_pkg::S_IDLE:
            begin
                if (in_acc)
                begin
                    acc_next   = acc_init;
                    clip_next  = sum_ovf;
                    state_next = ppid_pkg::S_MUL_I;
                end
            end
            ppid_pkg::S_MUL_I:
            begin
                mul_en     = 1'b1;
                mul_a      = sum_mag;
                mul_b      = cfg.integral_ratio;
                state_next = ppid_pkg::S_ADD_I;
            end
            ppid_pkg::S_ADD_I:
            begin
                acc_next   = acc_reg + term;
                clip_next  = clip_reg || cap_hit;
                state_next = ppid_pkg::S_MUL_D;
            end
            ppid_pkg::S_MUL_D:
            begin
                mul_en     = 1'b1;
                mul_a      = diff_mag;
                mul_b      = cfg.derivative_ratio;
                state_next = ppid_pkg::S_ADD_D;
            end
            ppid_pkg::S_ADD_D:
            begin
                acc_next   = acc_reg + term;
                clip_next  = clip_reg || cap_hit;
                state_next = ppid_pkg::S_MAG;
            end
            ppid_pkg::S_MAG:
            begin
                state_next = ppid_pkg::S_MUL_GL;
            end
            ppid_pkg::S_MUL_GL:
            begin
                mul_en     = 1'b1;
                mul_a      = mag_lo;
                mul_b      = cfg.gain;
                state_next = ppid_pkg::S_MUL_GH;
            end
            ppid_pkg::S_MUL_GH:
            begin
                mul_en     = 1'b1;
                mul_a      = mag_hi;
                mul_b      = cfg.gain;
                state_next = ppid_pkg::S_RND;
            end
            ppid_pkg::S_RND:
            begin
                // Hold here while the previous result still waits at the output.
                if (!m_tvalid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ppid_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ppid_pkg::S_IDLE;
            end
        endcase
    end

    // Control state and loop state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ppid_pkg::S_IDLE;
            m_tvalid_reg  <= 1'b0;
            clip_reg      <= 1'b0;
            error_sum_reg <= '0;
            prev_err_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clip_reg  <= clip_next;
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            if (in_acc)
            begin
                error_sum_reg <= sum_sat;
                prev_err_reg  <= err;
            end
        end
    end

    // Working datapath registers.
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (in_acc)
        begin
            diff_reg <= diff;
        end
        if (state_reg == ppid_pkg::S_MAG)
        begin
            neg_reg <= acc_reg[ACC_W-1];
            mag_reg <= acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
        end
        if (state_reg == ppid_pkg::S_MUL_GH)
        begin
            lo_reg <= prod;
        end
        if (out_load)
        begin
            drive_reg   <= drive_val;
            clipped_reg <= clip_reg || drive_ovf;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = ppid_pkg::M_TDATA_W'(drive_reg);
    assign m_tuser  = clipped_reg;

    // A new result appears only right after the round-and-saturate step.
    a_valid_from_rnd: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == ppid_pkg::S_RND))
        else $error("result raised outside the rounding step");

    // A taken sample always starts the integral multiply next.
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ppid_pkg::S_MUL_I))
        else $error("sequencer did not start after a sample was taken");

    // A stalled output holds the finished sample in the rounding step.
    a_rnd_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ppid_pkg::S_RND && m_tvalid && !m_tready)
        |=> (state_reg == ppid_pkg::S_RND))
        else $error("rounding step left while the output was stalled");

    // Loop state moves only when a sample is taken.
    a_state_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tvalid && s_tready) |=> ($stable(error_sum_reg) && $stable(prev_err_reg)))
        else $error("loop state changed without a sample");

endmodule

>>> sim/positional_pid_controller_tb.sv
// Self-checking testbench for the fixed-point positional PID controller.
module positional_pid_controller_tb;

    // Signed bounds of the running error sum.
    localparam longint SUM_HI = (longint'(1) <<< (ppid_pkg::SUM_W - 1)) - 1;
    localparam longint SUM_LO = -SUM_HI - 1;

    // Largest magnitude that a ratio product may take.
    localparam logic [127:0] TERM_LIMIT = (128'd1 << 61) - 1;

    // Cycles to let pass after the last result before touching the registers
    // or ending the run.
    localparam int DRAIN_CYCLES = 20;

    // Length of the long receiver hold-off that backs up the block.
    localparam int HOLDOFF_CYCLES = 300;

    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 240;

    // Expected drive values and clipped flags, computed from a private copy
    // of the controller state and registers.
    class drive_scoreboard;
        logic [ppid_pkg::SAMPLE_W-1:0] set_point;
        logic [ppid_pkg::RATIO_W-1:0]  gain;
        logic [ppid_pkg::RATIO_W-1:0]  integral_ratio;
        logic [ppid_pkg::RATIO_W-1:0]  derivative_ratio;
        longint                        error_sum;
        longint                        last_error;
        logic [ppid_pkg::DRIVE_W-1:0]  drive_q[$];
        bit                            clipped_q[$];
        int                            failures;

        function new();
            set_point        = ppid_pkg::SET_POINT_RST;
            gain             = ppid_pkg::RATIO_ONE;
            integral_ratio   = ppid_pkg::RATIO_ONE;
            derivative_ratio = ppid_pkg::RATIO_ONE;
            error_sum        = 0;
            last_error       = 0;
            failures         = 0;
        endfunction

        function void write_register(ppid_pkg::cfg_reg_t index,
                                     logic [ppid_pkg::CFG_DATA_W-1:0] value);
            case (index)
                ppid_pkg::REG_SET_POINT:  set_point        = value[ppid_pkg::SAMPLE_W-1:0];
                ppid_pkg::REG_GAIN:       gain             = value[ppid_pkg::RATIO_W-1:0];
                ppid_pkg::REG_INTEGRAL:   integral_ratio   = value[ppid_pkg::RATIO_W-1:0];
                ppid_pkg::REG_DERIVATIVE: derivative_ratio = value[ppid_pkg::RATIO_W-1:0];
                default: ;
            endcase
        endfunction

        // Exact product of a signed operand and a ratio, magnitude capped.
        function longint ratio_term(longint operand, logic [ppid_pkg::RATIO_W-1:0] ratio,
                                    inout bit clip);
            logic [127:0] mag;
            mag = (operand < 0) ? 128'(-operand) : 128'(operand);
            mag = mag * 128'(ratio);
            if (mag > TERM_LIMIT)
            begin
                clip = 1'b1;
                mag  = TERM_LIMIT;
            end
            return (operand < 0) ? -longint'(mag[62:0]) : longint'(mag[62:0]);
        endfunction

        function void note_sample(logic [ppid_pkg::SAMPLE_W-1:0] sample);
            longint       err;
            longint       sum;
            longint       bracket;
            bit           clip;
            bit           neg;
            logic [127:0] mag;
            logic [127:0] cap;
            clip = 1'b0;
            err  = longint'(set_point) - longint'(sample);
            sum  = error_sum + err;
            if (sum > SUM_HI)
            begin
                sum  = SUM_HI;
                clip = 1'b1;
            end
            else if (sum < SUM_LO)
            begin
                sum  = SUM_LO;
                clip = 1'b1;
            end
            bracket = err * (longint'(1) <<< ppid_pkg::GAIN_FRAC_W)
                    + ratio_term(sum, integral_ratio, clip)
                    + ratio_term(err - last_error, derivative_ratio, clip);
            // Gain product in Q.2F, rounded half away from zero on the magnitude.
            neg = bracket < 0;
            mag = neg ? 128'(-bracket) : 128'(bracket);
            mag = (mag * 128'(gain) + (128'd1 << (2 * ppid_pkg::GAIN_FRAC_W - 1)))
                  >> (2 * ppid_pkg::GAIN_FRAC_W);
            cap = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
            if (mag > cap)
            begin
                clip = 1'b1;
                mag  = cap;
            end
            drive_q.push_back(ppid_pkg::DRIVE_W'(neg ? -mag : mag));
            clipped_q.push_back(clip);
            error_sum  = sum;
            last_error = err;
        endfunction

        function void check_result(logic [ppid_pkg::DRIVE_W-1:0] drive, logic clipped);
            logic [ppid_pkg::DRIVE_W-1:0] want_drive;
            bit                           want_clipped;
            if (drive_q.size() == 0)
            begin
                $error("drive: no request outstanding, got %0d", $signed(drive));
                failures++;
                return;
            end
            want_drive   = drive_q.pop_front();
            want_clipped = clipped_q.pop_front();
            if (drive !== want_drive)
            begin
                $error("drive: expected %0d, got %0d", $signed(want_drive), $signed(drive));
                failures++;
            end
            if (clipped !== want_clipped)
            begin
                $error("clipped: expected %0b, got %0b", want_clipped, clipped);
                failures++;
            end
        endfunction

        function int pending();
            return drive_q.size();
        endfunction
    endclass

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             cfg_wr_en;
    logic [ppid_pkg::CFG_INDEX_W-1:0] cfg_wr_index;
    logic [ppid_pkg::CFG_DATA_W-1:0]  cfg_wr_data;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [ppid_pkg::S_TDATA_W-1:0]   s_tdata;   // [15:0] sample
    logic                             m_tvalid;
    logic                             m_tready;
    logic [ppid_pkg::M_TDATA_W-1:0]   m_tdata;   // [31:0] drive
    logic [0:0]                       m_tuser;   // [0] clipped

    drive_scoreboard sb;

    // Idle rates of the current phase, in percent of cycles; written only by
    // the stimulus process between phases.
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;

    // Bump to ask the receiver for one long hold-off.
    int holdoff_requests = 0;

    positional_pid_controller uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser)
    );

    always #2 clk = ~clk;

    // Sample both handshakes at the rising edge: check a finished result
    // first, then log the newly accepted request.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata[ppid_pkg::DRIVE_W-1:0], m_tuser[0]);
            if (s_tvalid && s_tready)
                sb.note_sample(s_tdata[ppid_pkg::SAMPLE_W-1:0]);
        end
    end

    // Receiver: stall at the phase rate, and serve each hold-off request by
    // dropping tready for a long count of cycles while the sender keeps going.
    initial
    begin : receiver
        int served;
        int hold_left;
        served    = 0;
        hold_left = 0;
        m_tready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left == 0 && served != holdoff_requests)
            begin
                served++;
                hold_left = HOLDOFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Offer one request; idle at the phase rate first, then hold the request
    // until the block takes it. tvalid stays high on return.
    task automatic send_sample(logic [ppid_pkg::SAMPLE_W-1:0] value);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= ppid_pkg::S_TDATA_W'(value);
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Drop tvalid, wait for every outstanding result, then let the block settle.
    task automatic wait_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(ppid_pkg::cfg_reg_t index,
                                  logic [ppid_pkg::CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= index;
        cfg_wr_data  <= value;
        sb.write_register(index, value);
    endtask

    // Write all four registers back to back; only call while idle. Random upper
    // bits ride along on the set point to exercise the width truncation.
    task automatic apply_settings(logic [ppid_pkg::SAMPLE_W-1:0] sp,
                                  logic [ppid_pkg::RATIO_W-1:0] g,
                                  logic [ppid_pkg::RATIO_W-1:0] ir,
                                  logic [ppid_pkg::RATIO_W-1:0] dr);
        logic [ppid_pkg::CFG_DATA_W-1:0] sp_word;
        sp_word                         = ppid_pkg::CFG_DATA_W'($urandom);
        sp_word[ppid_pkg::SAMPLE_W-1:0] = sp;
        write_register(ppid_pkg::REG_SET_POINT, sp_word);
        write_register(ppid_pkg::REG_GAIN, ppid_pkg::CFG_DATA_W'(g));
        write_register(ppid_pkg::REG_INTEGRAL, ppid_pkg::CFG_DATA_W'(ir));
        write_register(ppid_pkg::REG_DERIVATIVE, ppid_pkg::CFG_DATA_W'(dr));
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [ppid_pkg::RATIO_W-1:0] pick_ratio();
        case ($urandom_range(5))
            0:       return '0;
            1:       return ppid_pkg::RATIO_ONE;
            2:       return '1;
            3:       return ppid_pkg::RATIO_W'($urandom_range(255));
            default: return ppid_pkg::RATIO_W'($urandom);
        endcase
    endfunction

    function automatic logic [ppid_pkg::SAMPLE_W-1:0] pick_set_point();
        case ($urandom_range(3))
            0:       return '0;
            1:       return '1;
            default: return ppid_pkg::SAMPLE_W'($urandom);
        endcase
    endfunction

    // Mix full-range samples, rail values and samples close to the set point,
    // so that not every drive value lands on a bound.
    function automatic logic [ppid_pkg::SAMPLE_W-1:0] pick_sample();
        int near;
        case ($urandom_range(3))
            0: return $urandom_range(1) ? '1 : '0;
            1:
            begin
                near = int'(sb.set_point) + int'($urandom_range(512)) - 256;
                if (near < 0)
                    near = 0;
                if (near > int'({ppid_pkg::SAMPLE_W{1'b1}}))
                    near = int'({ppid_pkg::SAMPLE_W{1'b1}});
                return ppid_pkg::SAMPLE_W'(near);
            end
            default: return ppid_pkg::SAMPLE_W'($urandom);
        endcase
    endfunction

    initial
    begin : stimulus
        sb           = new();
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_index = ppid_pkg::REG_SET_POINT;
        cfg_wr_data  = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset register values: zero error, rail samples, mid-scale.
        send_sample(16'd1);
        send_sample(16'd0);
        send_sample(16'hFFFF);
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        send_sample(16'd1);
        wait_idle();

        // Full-scale gain and ratios: drive pinned at the positive bound, then
        // a large negative error step.
        apply_settings('1, '1, '1, '1);
        send_sample(16'd0);
        send_sample(16'd0);
        send_sample(16'hFFFF);
        wait_idle();

        // Same gains with zero set point: drive pinned at the negative bound.
        apply_settings('0, '1, '1, '1);
        send_sample(16'hFFFF);
        send_sample(16'hFFFF);
        send_sample(16'd0);
        wait_idle();

        // Zero ratios disable the integral and derivative terms.
        apply_settings(16'd40000, ppid_pkg::RATIO_ONE, '0, '0);
        send_sample(16'd0);
        send_sample(16'hFFFF);
        send_sample(16'd40000);
        wait_idle();

        // Zero gain forces a zero drive.
        apply_settings(16'd12345, '0, ppid_pkg::RATIO_ONE, ppid_pkg::RATIO_ONE);
        send_sample(16'd54321);
        send_sample(16'd12345);
        wait_idle();

        // Gain of one half on a bare proportional term: odd errors land on a
        // rounding tie, which must go away from zero in both signs.
        apply_settings(16'd30000, ppid_pkg::RATIO_W'(1 << (ppid_pkg::GAIN_FRAC_W - 1)),
                       '0, '0);
        send_sample(16'd29999);
        send_sample(16'd30001);
        send_sample(16'd29997);
        wait_idle();

        // Random phases: fresh registers each time, cycling through the idle
        // patterns; one phase also backs up the block with a long hold-off.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase % 4)
                0:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct    = 78;
                    receiver_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 78;
                end
                default:
                begin
                    sender_idle_pct    = 17;
                    receiver_stall_pct = 17;
                end
            endcase
            apply_settings(pick_set_point(), pick_ratio(), pick_ratio(), pick_ratio());
            if (phase == 4)
                holdoff_requests++;
            repeat (PHASE_ITEMS) send_sample(pick_sample());
            wait_idle();
        end

        // Run the largest positive error for a stretch, then swing to the most
        // negative error.
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        apply_settings('1, ppid_pkg::RATIO_ONE, ppid_pkg::RATIO_ONE, ppid_pkg::RATIO_ONE);
        repeat (8) send_sample('0);
        repeat (8) send_sample(ppid_pkg::SAMPLE_W'($urandom));
        wait_idle();
        apply_settings('0, ppid_pkg::RATIO_ONE, ppid_pkg::RATIO_ONE, ppid_pkg::RATIO_ONE);
        repeat (8) send_sample('1);
        wait_idle();

        if (sb.failures == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin : watchdog
        #6_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
